/* design/mpir_pkg.sv */
// Shared widths, register indexes and control types for the mesh piece index remap block.
package mpir_pkg;

  localparam int unsigned IDX_W   = 32;
  localparam int unsigned LOCAL_W = 8;
  localparam int unsigned PIECE_W = 16;
  localparam int unsigned LIMIT_W = 9;
  localparam int unsigned CORNERS = 3;

  localparam logic REG_MAX_VERTICES = 1'b0;
  localparam logic REG_VERTEX_COUNT = 1'b1;

  typedef struct packed {
    logic shift;
    logic compare;
  } chain_ctl_t;

endpackage

/* design/mpir_cell.sv */
// One remap cell: holds a single source index, shifts it on, and matches it against a key.
module mpir_cell #(
  parameter int unsigned POS    = 0,
  parameter int unsigned FILL_W = 2
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mpir_pkg::chain_ctl_t         ctl_i,
  input  logic [mpir_pkg::IDX_W-1:0]   key_i,
  input  logic [mpir_pkg::IDX_W-1:0]   prev_i,
  input  logic [FILL_W-1:0]            fill_i,
  output logic [mpir_pkg::IDX_W-1:0]   entry_o,
  output logic                         match_o
);

  logic [mpir_pkg::IDX_W-1:0] entry_q;
  logic                       match_q;
  logic                       live;

  // Entries are pushed in at the head, so this cell is in use once the fill passes it.
  assign live = FILL_W'(POS) < fill_i;

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      entry_q <= prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.compare) begin
      match_q <= live && (entry_q == key_i);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

/* design/mpir_chain.sv */
// Row of remap cells with the match collection that yields the matching position.
module mpir_chain #(
  parameter int unsigned N      = 256,
  parameter int unsigned POS_W  = 8,
  parameter int unsigned FILL_W = 9
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mpir_pkg::chain_ctl_t        ctl_i,
  input  logic [mpir_pkg::IDX_W-1:0]  key_i,
  input  logic [FILL_W-1:0]           fill_i,
  output logic                        found_o,
  output logic [POS_W-1:0]            pos_o
);

  logic [mpir_pkg::IDX_W-1:0] entry [N];
  logic [N-1:0]               match;

  for (genvar p = 0; p < N; p++) begin : g_cell
    logic [mpir_pkg::IDX_W-1:0] prev;
    if (p == 0) begin : g_head
      assign prev = key_i;
    end else begin : g_body
      assign prev = entry[p-1];
    end
    mpir_cell #(
      .POS    (p),
      .FILL_W (FILL_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_i),
      .key_i   (key_i),
      .prev_i  (prev),
      .fill_i  (fill_i),
      .entry_o (entry[p]),
      .match_o (match[p])
    );
  end

  // Entries of one piece are distinct, so at most one cell matches.
  always_comb begin
    pos_o = '0;
    for (int unsigned p = 0; p < N; p++) begin
      if (match[p]) begin
        pos_o = pos_o | POS_W'(p);
      end
    end
  end

  assign found_o = |match;

endmodule

/* design/mesh_piece_index_remap_top.sv */
// Top level of the mesh piece index remap block: control, configuration and results.
// Each item runs through a check state, then a compare and a resolve state for each corner in
// turn, and ends in the idle state in which the result is shown; a bad triangle returns to idle
// from the check state. A new item is taken once the last result is shown, and the receiver
// cannot stall; busy falls in the cycle the result is shown. Reset clears the piece fill, the
// counter, control state and cell match flags and loads configuration defaults; cell entries stay.
module mesh_piece_index_remap_top #(
  parameter int unsigned MAX_PIECE_VERTICES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [mpir_pkg::IDX_W-1:0]          corner_a_i,
  input  logic [mpir_pkg::IDX_W-1:0]          corner_b_i,
  input  logic [mpir_pkg::IDX_W-1:0]          corner_c_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [mpir_pkg::IDX_W-1:0]          cfg_data_i,
  output logic                                result_valid_o,
  output logic [mpir_pkg::PIECE_W-1:0]        piece_number_o,
  output logic                                opened_piece_o,
  output logic [mpir_pkg::LOCAL_W-1:0]        local_a_o,
  output logic [mpir_pkg::LOCAL_W-1:0]        local_b_o,
  output logic [mpir_pkg::LOCAL_W-1:0]        local_c_o,
  output logic                                fresh_a_o,
  output logic                                fresh_b_o,
  output logic                                fresh_c_o,
  output logic                                bad_index_o
);

  localparam int unsigned N     = MAX_PIECE_VERTICES;
  localparam int unsigned POS_W = $clog2(N);
  localparam int unsigned FILL_W = $clog2(N + 1);
  localparam int unsigned LIM_W =
      ((FILL_W > mpir_pkg::LIMIT_W) ? FILL_W : mpir_pkg::LIMIT_W) + 1;
  localparam int unsigned LOC_X_W =
      (FILL_W > mpir_pkg::LOCAL_W) ? FILL_W : mpir_pkg::LOCAL_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_CMP   = 2'd2;
  localparam logic [1:0] S_RES   = 2'd3;

  localparam logic [1:0] LAST_CORNER = 2'(mpir_pkg::CORNERS - 1);

  logic [1:0]                       state_q, state_d;
  logic [1:0]                       k_q;
  logic [mpir_pkg::IDX_W-1:0]       corner_q [mpir_pkg::CORNERS];
  logic [FILL_W-1:0]                fill_q;
  logic [mpir_pkg::PIECE_W-1:0]     counter_q;
  logic [mpir_pkg::LIMIT_W-1:0]     max_vertices_q;
  logic [mpir_pkg::IDX_W-1:0]       vertex_count_q;
  logic                             result_valid_q;
  logic                             opened_q;
  logic                             bad_q;
  logic [mpir_pkg::LOCAL_W-1:0]     local_q [mpir_pkg::CORNERS];
  logic                             fresh_q [mpir_pkg::CORNERS];

  logic                             accept;
  logic                             any_bad;
  logic [LIM_W-1:0]                 limit;
  logic                             need_open;
  logic [mpir_pkg::PIECE_W-1:0]     counter_next;
  logic [mpir_pkg::IDX_W-1:0]       key;
  mpir_pkg::chain_ctl_t             ctl;
  logic                             found;
  logic [POS_W-1:0]                 pos;
  logic [LOC_X_W-1:0]               local_x;

  assign accept      = start && !busy;
  assign busy        = state_q != S_IDLE;
  assign cfg_ready_o = 1'b1;

  assign any_bad = (corner_q[0] >= vertex_count_q) || (corner_q[1] >= vertex_count_q) ||
                   (corner_q[2] >= vertex_count_q);

  always_comb begin
    if (max_vertices_q < mpir_pkg::LIMIT_W'(mpir_pkg::CORNERS)) begin
      limit = LIM_W'(mpir_pkg::CORNERS);
    end else if (LIM_W'(max_vertices_q) > LIM_W'(N)) begin
      limit = LIM_W'(N);
    end else begin
      limit = LIM_W'(max_vertices_q);
    end
  end

  assign need_open    = (LIM_W'(fill_q) + LIM_W'(mpir_pkg::CORNERS)) > limit;
  assign counter_next = (counter_q != '1) ? counter_q + 1'b1 : counter_q;

  assign key         = corner_q[k_q];
  assign ctl.compare = state_q == S_CMP;
  assign ctl.shift   = (state_q == S_RES) && !found;

  assign local_x = found ? (LOC_X_W'(fill_q) - LOC_X_W'(1) - LOC_X_W'(pos))
                         : LOC_X_W'(fill_q);

  mpir_chain #(
    .N      (N),
    .POS_W  (POS_W),
    .FILL_W (FILL_W)
  ) u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .key_i   (key),
    .fill_i  (fill_q),
    .found_o (found),
    .pos_o   (pos)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        state_d = any_bad ? S_IDLE : S_CMP;
      end
      S_CMP: begin
        state_d = S_RES;
      end
      S_RES: begin
        state_d = (k_q == LAST_CORNER) ? S_IDLE : S_CMP;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      k_q            <= '0;
      fill_q         <= '0;
      counter_q      <= '0;
      max_vertices_q <= mpir_pkg::LIMIT_W'(256);
      vertex_count_q <= '0;
      result_valid_q <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          mpir_pkg::REG_MAX_VERTICES: max_vertices_q <= cfg_data_i[mpir_pkg::LIMIT_W-1:0];
          mpir_pkg::REG_VERTEX_COUNT: vertex_count_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_CHECK) begin
        k_q <= '0;
        if (any_bad) begin
          result_valid_q <= 1'b1;
        end else if (need_open) begin
          fill_q    <= '0;
          counter_q <= counter_next;
        end
      end
      if (state_q == S_RES) begin
        k_q <= k_q + 1'b1;
        if (!found) begin
          fill_q <= fill_q + FILL_W'(1);
        end
        if (k_q == LAST_CORNER) begin
          result_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      corner_q[0] <= corner_a_i;
      corner_q[1] <= corner_b_i;
      corner_q[2] <= corner_c_i;
    end
    if (state_q == S_CHECK) begin
      bad_q <= any_bad;
      if (any_bad) begin
        opened_q <= 1'b0;
        for (int unsigned i = 0; i < mpir_pkg::CORNERS; i++) begin
          local_q[i] <= '0;
          fresh_q[i] <= 1'b0;
        end
      end else begin
        opened_q <= need_open;
      end
    end
    if (state_q == S_RES) begin
      local_q[k_q] <= local_x[mpir_pkg::LOCAL_W-1:0];
      fresh_q[k_q] <= !found;
    end
  end

  assign result_valid_o = result_valid_q;
  assign piece_number_o = bad_q ? '0 : counter_q;
  assign opened_piece_o = opened_q;
  assign local_a_o      = local_q[0];
  assign local_b_o      = local_q[1];
  assign local_c_o      = local_q[2];
  assign fresh_a_o      = fresh_q[0];
  assign fresh_b_o      = fresh_q[1];
  assign fresh_c_o      = fresh_q[2];
  assign bad_index_o    = bad_q;

`ifndef ASSERT_OFF
  a_bad_clears_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && bad_index_o |-> !opened_piece_o && !fresh_a_o && !fresh_b_o &&
      !fresh_c_o && local_a_o == '0 && local_b_o == '0 && local_c_o == '0)
    else $error("bad triangle result carries non-zero fields");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    LIM_W'(fill_q) <= LIM_W'(N))
    else $error("piece fill exceeds the cell count");

  a_open_starts_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && opened_piece_o |-> fresh_a_o && local_a_o == '0)
    else $error("new piece did not start with a fresh first corner");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy && !result_valid_o)
    else $error("accepted item did not raise busy");
`endif

endmodule
